@@ design/eprm_pkg.sv @@
// ----------------------------------------------------------------------------
// Encoder period RPM meter package
// Shared transaction types, register indexes, reset values and state codes.
// ----------------------------------------------------------------------------
package eprm_pkg;

   localparam int SUBTICK_W  = 24;
   localparam int SLICES_W   = 25;
   localparam int WORD_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int STEP_CNT_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_SLICES_PER_MS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_NUMERATOR = 2'd1;

   localparam logic [SLICES_W-1:0] SLICES_RESET    = 25'd9000;
   localparam logic [WORD_W-1:0]   NUMERATOR_RESET = 32'd45000000;

   localparam logic [STEP_CNT_W-1:0] MUL_LAST_STEP = 5'(SLICES_W - 1);
   localparam logic [STEP_CNT_W-1:0] DIV_LAST_STEP = 5'(WORD_W - 1);

   typedef struct packed {
      logic                 command;
      logic [SUBTICK_W-1:0] subtick_value;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] rpm_value;
      logic              measured;
      logic              zero_interval;
      logic [WORD_W-1:0] event_count;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   localparam logic CMD_MS_TICK = 1'b0;
   localparam logic CMD_EVENT   = 1'b1;

endpackage

@@ design/encoder_period_rpm_meter.sv @@
// ----------------------------------------------------------------------------
// Encoder period RPM meter
// Forms the fine-tick interval between encoder events with a bit-serial
// multiplier and divides the configured numerator by it bit-serially.
// ----------------------------------------------------------------------------
// A millisecond tick goes from ST_IDLE straight to ST_DONE; an encoder event
// passes through ST_MUL and ST_DIV first (ST_MUL only when the interval is
// zero). The result is registered in ST_DONE once the output is free.
// A new request is taken only back in ST_IDLE, so an event holds the meter for
// the 25-step shift-add multiplier followed by the 32-step restoring divider.
// Reset: synchronous; counters and timestamps clear, registers take defaults.
module encoder_period_rpm_meter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  eprm_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output eprm_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [eprm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [eprm_pkg::WORD_W-1:0]         csr_data
);
   import eprm_pkg::*;

   state_type             state_ff, state_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SLICES_W-1:0]   slices_ff, slices_in;
   logic [WORD_W-1:0]     numerator_ff, numerator_in;
   logic [WORD_W-1:0]     ms_counter_ff, ms_counter_in;
   logic [WORD_W-1:0]     last_ms_ff, last_ms_in;
   logic [SUBTICK_W-1:0]  last_sub_ff, last_sub_in;
   logic [WORD_W-1:0]     events_ff, events_in;
   logic [WORD_W-1:0]     rpm_ff, rpm_in;
   logic                  measured_ff, measured_in;
   logic                  zero_ff, zero_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic [WORD_W-1:0]     mcand_ff, mcand_in;
   logic [SLICES_W-1:0]   mplier_ff, mplier_in;
   logic [WORD_W-1:0]     acc_ff, acc_in;
   logic [WORD_W-1:0]     rem_ff, rem_in;
   logic [WORD_W-1:0]     quo_ff, quo_in;
   logic [WORD_W-1:0]     divisor_ff, divisor_in;
   logic [WORD_W+1:0]     trial;
   logic                  req_fire;
   logic                  rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign trial     = {1'b0, rem_ff, quo_ff[WORD_W-1]} - {2'b00, divisor_ff};

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      slices_in     = slices_ff;
      numerator_in  = numerator_ff;
      ms_counter_in = ms_counter_ff;
      last_ms_in    = last_ms_ff;
      last_sub_in   = last_sub_ff;
      events_in     = events_ff;
      rpm_in        = rpm_ff;
      measured_in   = measured_ff;
      zero_in       = zero_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      mcand_in      = mcand_ff;
      mplier_in     = mplier_ff;
      acc_in        = acc_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      divisor_in    = divisor_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_SLICES_PER_MS:  slices_in    = csr_data[SLICES_W-1:0];
            CSR_RATE_NUMERATOR: numerator_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.command == CMD_EVENT) begin
                  mcand_in    = ms_counter_ff - last_ms_ff;
                  mplier_in   = slices_ff;
                  acc_in      = {8'd0, last_sub_ff} - {8'd0, req_data.subtick_value};
                  cnt_in      = MUL_LAST_STEP;
                  last_ms_in  = ms_counter_ff;
                  last_sub_in = req_data.subtick_value;
                  events_in   = events_ff + 32'd1;
                  measured_in = 1'b1;
                  zero_in     = 1'b0;
                  state_in    = ST_MUL;
               end else begin
                  ms_counter_in = ms_counter_ff + 32'd1;
                  measured_in   = 1'b0;
                  zero_in       = 1'b0;
                  state_in      = ST_DONE;
               end
            end
         end
         ST_MUL: begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = {mcand_ff[WORD_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[SLICES_W-1:1]};
            cnt_in    = cnt_ff - 5'd1;
            if (cnt_ff == '0) begin
               if (acc_in == '0) begin
                  rpm_in   = '1;
                  zero_in  = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  divisor_in = acc_in;
                  rem_in     = '0;
                  quo_in     = numerator_ff;
                  cnt_in     = DIV_LAST_STEP;
                  state_in   = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (trial[WORD_W+1]) begin
               rem_in = {rem_ff[WORD_W-2:0], quo_ff[WORD_W-1]};
            end else begin
               rem_in = trial[WORD_W-1:0];
            end
            quo_in = {quo_ff[WORD_W-2:0], !trial[WORD_W+1]};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == '0) begin
               rpm_in   = quo_in;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.rpm_value     = rpm_ff;
               rsp_in.measured      = measured_ff;
               rsp_in.zero_interval = zero_ff;
               rsp_in.event_count   = events_ff;
               state_in             = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         slices_ff     <= SLICES_RESET;
         numerator_ff  <= NUMERATOR_RESET;
         ms_counter_ff <= '0;
         last_ms_ff    <= '0;
         last_sub_ff   <= '0;
         events_ff     <= '0;
         rpm_ff        <= '0;
         measured_ff   <= 1'b0;
         zero_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         slices_ff     <= slices_in;
         numerator_ff  <= numerator_in;
         ms_counter_ff <= ms_counter_in;
         last_ms_ff    <= last_ms_in;
         last_sub_ff   <= last_sub_in;
         events_ff     <= events_in;
         rpm_ff        <= rpm_in;
         measured_ff   <= measured_in;
         zero_ff       <= zero_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff     <= rsp_in;
      mcand_ff   <= mcand_in;
      mplier_ff  <= mplier_in;
      acc_ff     <= acc_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   a_zero_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.zero_interval |-> rsp_ff.rpm_value == '1 && rsp_ff.measured)
      else $error("zero interval reported without saturated measurement");

   a_tick_no_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.measured |-> !rsp_ff.zero_interval)
      else $error("zero interval flagged on a millisecond tick");

   a_event_starts_mul: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.command == CMD_EVENT |=> state_ff == ST_MUL)
      else $error("encoder event did not start the multiplier");

   a_tick_counts: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.command == CMD_MS_TICK
      |=> ms_counter_ff == $past(ms_counter_ff) + 32'd1)
      else $error("millisecond tick not counted");

   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV && cnt_ff == '0 |=> state_ff == ST_DONE)
      else $error("divider did not finish after its last step");

endmodule

@@ sim/eprm_reading_checker.sv @@
// ----------------------------------------------------------------------------
// Encoder period RPM meter reading checker
// Watches the register, request and response channels of the meter. It keeps
// its own copy of the millisecond count, last event timestamp, event total
// and register values, and predicts one reading for every accepted request
// transaction. Each accepted response transaction is compared field by field
// with the oldest predicted reading. Failures are counted for the test top.
// ----------------------------------------------------------------------------
module eprm_reading_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  eprm_pkg::req_type              req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  eprm_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [eprm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [eprm_pkg::WORD_W-1:0]    csr_data,
   output int                             fail_count,
   output int                             pending_count,
   output int                             result_count,
   output int                             measurement_count,
   output int                             saturation_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import eprm_pkg::*;

   localparam int REPORT_LIMIT = 100;

   logic [SLICES_W-1:0]  cfg_slices    = SLICES_RESET;
   logic [WORD_W-1:0]    cfg_numerator = NUMERATOR_RESET;
   logic [WORD_W-1:0]    tick_count    = '0;
   logic [WORD_W-1:0]    prev_event_ms = '0;
   logic [SUBTICK_W-1:0] prev_subtick  = '0;
   logic [WORD_W-1:0]    event_total   = '0;
   logic [WORD_W-1:0]    last_rpm      = '0;

   rsp_type expected_readings[$];
   rsp_type oldest_reading;

   int failures     = 0;
   int waiting      = 0;
   int results      = 0;
   int measurements = 0;
   int saturations  = 0;

   assign fail_count        = failures;
   assign pending_count     = waiting;
   assign result_count      = results;
   assign measurement_count = measurements;
   assign saturation_count  = saturations;

   function automatic rsp_type predict_reading(input req_type item);
      rsp_type              reading;
      logic [WORD_W-1:0]    ms_gap;
      logic [2*WORD_W-1:0]  product;
      logic [WORD_W-1:0]    interval;
      reading = '0;
      if (item.command == CMD_MS_TICK) begin
         tick_count = tick_count + 1'b1;
      end else begin
         ms_gap   = tick_count - prev_event_ms;
         product  = (2*WORD_W)'(cfg_slices) * (2*WORD_W)'(ms_gap);
         interval = product[WORD_W-1:0] + WORD_W'(prev_subtick)
                    - WORD_W'(item.subtick_value);
         event_total = event_total + 1'b1;
         if (interval == '0) begin
            last_rpm              = '1;
            reading.zero_interval = 1'b1;
         end else begin
            last_rpm = cfg_numerator / interval;
         end
         reading.measured = 1'b1;
         prev_subtick     = item.subtick_value;
         prev_event_ms    = tick_count;
      end
      reading.rpm_value   = last_rpm;
      reading.event_count = event_total;
      return reading;
   endfunction

   task automatic note_failure(input string what);
      failures++;
      if (failures <= REPORT_LIMIT) begin
         $error("%s", what);
      end else if (failures == REPORT_LIMIT + 1) begin
         $display("Further mismatches are counted but not reported.");
      end
   endtask

   task automatic check_field(input string field, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
      if (got !== want) begin
         note_failure($sformatf("%s: expected %0d, got %0d", field, want, got));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_slices    = SLICES_RESET;
         cfg_numerator = NUMERATOR_RESET;
         tick_count    = '0;
         prev_event_ms = '0;
         prev_subtick  = '0;
         event_total   = '0;
         last_rpm      = '0;
         expected_readings.delete();
         waiting = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SLICES_PER_MS:  cfg_slices    = csr_data[SLICES_W-1:0];
               CSR_RATE_NUMERATOR: cfg_numerator = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            results++;
            if (expected_readings.size() == 0) begin
               note_failure($sformatf("unexpected result transaction: rpm_value %0d, %s %0d",
                                      rsp_data.rpm_value, "event_count",
                                      rsp_data.event_count));
            end else begin
               oldest_reading = expected_readings.pop_front();
               if (oldest_reading.measured) measurements++;
               if (oldest_reading.zero_interval) saturations++;
               check_field("rpm_value", oldest_reading.rpm_value, rsp_data.rpm_value);
               check_field("measured", WORD_W'(oldest_reading.measured),
                           WORD_W'(rsp_data.measured));
               check_field("zero_interval", WORD_W'(oldest_reading.zero_interval),
                           WORD_W'(rsp_data.zero_interval));
               check_field("event_count", oldest_reading.event_count,
                           rsp_data.event_count);
            end
         end
         if (req_valid && req_ready) begin
            expected_readings.push_back(predict_reading(req_data));
         end
         waiting = expected_readings.size();
      end
   end

endmodule

@@ sim/tb_encoder_period_rpm_meter.sv @@
// ----------------------------------------------------------------------------
// Encoder period RPM meter testbench
// Drives millisecond ticks and encoder events into the meter under a series
// of register settings, starting with a directed sequence of edge cases and
// then random tick and event sequences, some aimed at exact small intervals.
// The sender works in bursts and the receiver stalls; a separate checker
// predicts and compares every reading.
// ----------------------------------------------------------------------------
module tb_encoder_period_rpm_meter;
   timeunit 1ns;
   timeprecision 1ps;

   import eprm_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;
   localparam logic [SLICES_W-1:0]  SLICES_MAX   = 25'h100_0000;
   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 103;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0]    csr_data  = '0;

   int fail_count;
   int pending_count;
   int result_count;
   int measurement_count;
   int saturation_count;

   logic [SLICES_W-1:0]  slices_now        = SLICES_RESET;
   logic [SUBTICK_W-1:0] last_subtick      = '0;
   int                   ticks_since_event = 0;
   int                   items_sent        = 0;
   int                   burst_left        = 0;
   int                   settings_used     = 1;
   int                   rx_cycle          = 0;
   int                   rx_hold           = 0;

   encoder_period_rpm_meter u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   eprm_reading_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data          (rsp_data),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .fail_count        (fail_count),
      .pending_count     (pending_count),
      .result_count      (result_count),
      .measurement_count (measurement_count),
      .saturation_count  (saturation_count)
   );

   always #5 clock = ~clock;

   // The receiver cycles through free running, random, long-stall and
   // periodic patterns.
   always @(negedge clock) begin
      rx_cycle = rx_cycle + 1;
      case ((rx_cycle / 400) % 4)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(3, 0) != 0);
         2: begin
            if (rx_hold > 0) begin
               rx_hold = rx_hold - 1;
               rsp_ready <= 1'b0;
            end else if ($urandom_range(7, 0) == 0) begin
               rx_hold = $urandom_range(60, 1);
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
         default: rsp_ready <= ((rx_cycle % 3) != 0);
      endcase
   end

   task automatic send_item(input logic cmd, input logic [SUBTICK_W-1:0] sub);
      req_type item;
      int      gap;
      item.command       = cmd;
      item.subtick_value = sub;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (cmd == CMD_EVENT) begin
         last_subtick      = sub;
         ticks_since_event = 0;
      end else begin
         ticks_since_event++;
      end
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap        = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(20, 1);
         burst_left = $urandom_range(12, 0);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_SLICES_PER_MS) slices_now = value[SLICES_W-1:0];
      @(negedge clock);
   endtask

   task automatic configure(input logic [WORD_W-1:0] slices, input logic [WORD_W-1:0] numerator,
                            input logic spare);
      drain_results();
      write_reg(CSR_SLICES_PER_MS, slices);
      write_reg(CSR_RATE_NUMERATOR, numerator);
      if (spare) begin
         write_reg(CSR_SPARE_LO, '1);
         write_reg(CSR_SPARE_HI, '1);
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic random_sequence();
      int unsigned       pick;
      int unsigned       ticks;
      int unsigned       sub_top;
      logic [WORD_W-1:0] target;
      pick = $urandom_range(99, 0);
      if (pick < 50) begin
         // Ticks followed by an event whose subtick lies within one millisecond.
         ticks = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 1) : $urandom_range(4, 0);
         repeat (ticks) send_item(CMD_MS_TICK, SUBTICK_W'($urandom));
         if (slices_now == '0) sub_top = 0;
         else if (slices_now > SLICES_W'(24'hFF_FFFF)) sub_top = 32'h00FF_FFFF;
         else sub_top = slices_now - 1'b1;
         send_item(CMD_EVENT, SUBTICK_W'($urandom_range(sub_top, 0)));
      end else if (pick < 65) begin
         // Aim the event at an interval of zero, one or two fine ticks.
         if ($urandom_range(1, 0) == 1) send_item(CMD_MS_TICK, SUBTICK_W'($urandom));
         target = WORD_W'(slices_now) * WORD_W'(ticks_since_event) + WORD_W'(last_subtick)
                  - WORD_W'($urandom_range(2, 0));
         if (target <= 32'h00FF_FFFF) send_item(CMD_EVENT, target[SUBTICK_W-1:0]);
         else send_item(CMD_EVENT, last_subtick);
      end else if (pick < 75) begin
         send_item(CMD_EVENT, ($urandom_range(1, 0) == 1) ? '1 : '0);
      end else begin
         send_item(($urandom_range(1, 0) == 1) ? CMD_EVENT : CMD_MS_TICK,
                   SUBTICK_W'($urandom));
      end
   endtask

   initial begin
      logic [WORD_W-1:0] slices;
      logic [WORD_W-1:0] numerator;
      int                phase_end;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Both timestamps are zero after reset, so a zero subtick gives a zero interval.
      send_item(CMD_EVENT, '0);
      send_item(CMD_MS_TICK, '1);
      send_item(CMD_EVENT, '1);
      send_item(CMD_EVENT, '1);
      repeat (3) send_item(CMD_MS_TICK, '0);
      send_item(CMD_EVENT, '0);
      send_item(CMD_EVENT, 24'h55_5555);
      send_item(CMD_MS_TICK, 24'hAA_AAAA);
      send_item(CMD_EVENT, 24'hAA_AAAA);

      // With no slices per millisecond only the subticks count; a zero numerator gives 0.
      configure('0, '0, 1'b0);
      send_item(CMD_EVENT, 24'h00_04D2);
      send_item(CMD_MS_TICK, '0);
      send_item(CMD_EVENT, 24'h00_04D2);
      send_item(CMD_EVENT, '0);

      configure(WORD_W'(SLICES_MAX), '1, 1'b0);
      send_item(CMD_MS_TICK, '0);
      send_item(CMD_EVENT, '0);
      repeat (2) send_item(CMD_MS_TICK, '1);
      send_item(CMD_EVENT, '1);

      // Slices written with every bit set must be cut to the register width,
      // and writes to unused indexes must change nothing.
      configure('1, 32'd1, 1'b1);
      send_item(CMD_EVENT, 24'h80_0000);
      send_item(CMD_MS_TICK, '0);
      send_item(CMD_EVENT, '0);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 5)
            0: begin
               slices    = WORD_W'(SLICES_RESET);
               numerator = NUMERATOR_RESET;
            end
            1: begin
               slices    = 32'd1;
               numerator = '1;
            end
            2: begin
               slices    = WORD_W'(SLICES_MAX);
               numerator = 32'd1;
            end
            3: begin
               slices    = $urandom_range(64, 1);
               numerator = $urandom;
            end
            default: begin
               slices    = (phase == RANDOM_PHASES - 1) ? '0 : $urandom_range(SLICES_MAX, 1);
               numerator = $urandom;
            end
         endcase
         configure(slices, numerator, ($urandom_range(1, 0) == 1));
         phase_end = items_sent + ITEMS_PER_PHASE;
         while (items_sent < phase_end) begin
            if ($urandom_range(59, 0) == 0) drain_results();
            random_sequence();
         end
      end

      drain_results();
      repeat (60) @(negedge clock);
      $display("Run covered %0d request transactions over %0d register settings.",
               items_sent, settings_used);
      $display("Checked %0d results: %0d measurements, %0d of them on a zero interval.",
               result_count, measurement_count, saturation_count);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Timeout: stimulus or results did not complete.");
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
